@@ rtl/rsld_pkg.sv @@
// Package for the run-length sprite line decoder.
// Holds the transfer payload types, the decoder phase type and the stream codes.
// Not used by rsld_ram; used by rle_sprite_line_decoder_unit.
package rsld_pkg;

    localparam int MAX_LINE_WIDTH_DEF = 1023;
    localparam int LINE_WIDTH_W       = 10;
    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = 10'd640;
    localparam int PALETTE_DEPTH      = 256;
    localparam int PALETTE_W          = 8;
    localparam int PADDR_W            = 3;
    localparam int PDATA_W            = 32;

    localparam logic [PADDR_W-3:0] REG_LINE_WIDTH = 1'b0;

    localparam logic       KIND_STREAM = 1'b0;
    localparam logic       KIND_TABLE  = 1'b1;

    localparam logic [7:0] LT_DIRECT = 8'd0;
    localparam logic [7:0] LT_SIGNED = 8'd1;
    localparam logic [7:0] LT_SKIP   = 8'd2;
    localparam logic [7:0] LT_PAIRS  = 8'd3;
    localparam logic [7:0] LT_EMPTY  = 8'd4;
    localparam logic [7:0] END_MARK  = 8'hFF;

    localparam logic [1:0] SK_PIXELS  = 2'd0;
    localparam logic [1:0] SK_SKIP    = 2'd1;
    localparam logic [1:0] SK_EOL     = 2'd2;
    localparam logic [1:0] SK_UNKNOWN = 2'd3;

    typedef enum logic [2:0] {
        PH_TYPE    = 3'd0,
        PH_DIRECT  = 3'd1,
        PH_COUNT   = 3'd2,
        PH_LITERAL = 3'd3,
        PH_REPEAT  = 3'd4,
        PH_LEAD    = 3'd5,
        PH_TERM    = 3'd6
    } t_phase;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] table_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0] span_kind;
        logic [7:0] pixel;
        logic [7:0] span_length;
        logic       last_of_line;
    } t_out_item;

    typedef struct packed {
        logic [1:0] span_kind;
        logic [7:0] span_length;
        logic       last_of_line;
        logic       use_pixel;
    } t_span_meta;

endpackage

@@ rtl/rle_sprite_line_decoder_unit.sv @@
// Run-length sprite line decoder: top level with control, palette RAM and output register.
// Depends on rsld_pkg and rsld_ram.
//
// The block takes one transfer per clock cycle on its input channel unless it stalls,
// either a compressed stream byte or a palette write, and delivers at most one span per
// stream byte. The synchronous palette RAM is read at the accepting edge; the span then
// passes from the stage-1 register to the output register. With the output side not
// stalling, one byte is taken every cycle; the single-port palette RAM, shared by stream
// reads and table writes, sets that figure. The palette has no reset, so every entry must
// be written before a stream byte refers to it. line_width sits at byte address 0 of the APB
// port; the user must write it only while the block is idle; the block does not enforce it.
module rle_sprite_line_decoder_unit #(
    parameter int MAX_LINE_WIDTH = rsld_pkg::MAX_LINE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  rsld_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output rsld_pkg::t_out_item           o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rsld_pkg::PADDR_W-1:0]  paddr,
    input  logic [rsld_pkg::PDATA_W-1:0]  pwdata,
    output logic [rsld_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int CAP   = (MAX_LINE_WIDTH < 1023) ? MAX_LINE_WIDTH : 1023;
    localparam int CW    = $clog2(CAP + 1);
    localparam int BL_W  = (CW > 8) ? CW : 8;
    localparam int LW_W  = rsld_pkg::LINE_WIDTH_W;

    logic [LW_W-1:0]          r_line_width;
    rsld_pkg::t_phase         r_phase,  n_phase;
    logic [1:0]               r_line_kind, n_line_kind;
    logic [BL_W-1:0]          r_bytes_left, n_bytes_left;
    logic [6:0]               r_repeat, n_repeat;
    logic                     r_s1_valid, n_s1_valid;
    rsld_pkg::t_span_meta     r_s1_meta;
    logic                     r_out_valid, n_out_valid;
    rsld_pkg::t_out_item      r_out;

    logic                     s1_move;
    logic                     in_accept;
    logic                     stream_accept;
    logic [7:0]               b;
    logic [BL_W-1:0]          w_sat;
    logic [BL_W-1:0]          bl_dec;
    logic [7:0]               neg_count;
    logic                     emit;
    rsld_pkg::t_span_meta     span;
    logic [7:0]               ram_rdata;
    logic                     cfg_write;

    assign b             = i_in_data.data_byte;
    assign s1_move       = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall    = r_s1_valid && !s1_move;
    assign in_accept     = i_in_valid && !o_in_stall;
    assign stream_accept = in_accept && (i_in_data.kind == rsld_pkg::KIND_STREAM);

    assign w_sat     = (32'(r_line_width) > CAP) ? BL_W'(CAP) : BL_W'(r_line_width);
    assign bl_dec    = (r_bytes_left != '0) ? (r_bytes_left - BL_W'(1)) : r_bytes_left;
    assign neg_count = 8'd0 - b;

    always_comb begin
        n_phase      = r_phase;
        n_line_kind  = r_line_kind;
        n_bytes_left = r_bytes_left;
        n_repeat     = r_repeat;
        case (r_phase)
            rsld_pkg::PH_TYPE: begin
                case (b) inside
                    rsld_pkg::LT_DIRECT: begin
                        n_line_kind = 2'd0;
                        if (w_sat != '0) begin
                            n_bytes_left = w_sat;
                            n_phase      = rsld_pkg::PH_DIRECT;
                        end
                    end
                    rsld_pkg::LT_SIGNED, rsld_pkg::LT_SKIP: begin
                        n_line_kind = b[1:0];
                        n_phase     = rsld_pkg::PH_COUNT;
                    end
                    rsld_pkg::LT_PAIRS: begin
                        n_line_kind = 2'd3;
                        n_phase     = rsld_pkg::PH_LEAD;
                    end
                    default: begin
                    end
                endcase
            end
            rsld_pkg::PH_DIRECT: begin
                n_bytes_left = bl_dec;
                if (bl_dec == '0) begin
                    n_phase = rsld_pkg::PH_TYPE;
                end
            end
            rsld_pkg::PH_COUNT: begin
                if (b == 8'd0) begin
                    n_phase = (r_line_kind == 2'd3) ? rsld_pkg::PH_TERM : rsld_pkg::PH_TYPE;
                end else if (b[7]) begin
                    n_bytes_left = BL_W'(neg_count);
                    n_phase      = rsld_pkg::PH_LITERAL;
                end else if (r_line_kind != 2'd2) begin
                    n_repeat = b[6:0];
                    n_phase  = rsld_pkg::PH_REPEAT;
                end
            end
            rsld_pkg::PH_LITERAL: begin
                n_bytes_left = bl_dec;
                if (bl_dec == '0) begin
                    n_phase = (r_line_kind == 2'd3) ? rsld_pkg::PH_TERM : rsld_pkg::PH_COUNT;
                end
            end
            rsld_pkg::PH_REPEAT: begin
                n_phase = (r_line_kind == 2'd3) ? rsld_pkg::PH_TERM : rsld_pkg::PH_COUNT;
            end
            rsld_pkg::PH_LEAD: begin
                n_phase = rsld_pkg::PH_COUNT;
            end
            rsld_pkg::PH_TERM: begin
                n_phase = (b == rsld_pkg::END_MARK) ? rsld_pkg::PH_TYPE : rsld_pkg::PH_COUNT;
            end
            default: begin
                n_phase = rsld_pkg::PH_TYPE;
            end
        endcase
    end

    always_comb begin
        emit              = 1'b0;
        span.span_kind    = rsld_pkg::SK_PIXELS;
        span.span_length  = 8'd0;
        span.last_of_line = 1'b0;
        span.use_pixel    = 1'b0;
        case (r_phase)
            rsld_pkg::PH_TYPE: begin
                case (b) inside
                    rsld_pkg::LT_DIRECT: begin
                        if (w_sat == '0) begin
                            emit              = 1'b1;
                            span.span_kind    = rsld_pkg::SK_EOL;
                            span.last_of_line = 1'b1;
                        end
                    end
                    rsld_pkg::LT_SIGNED, rsld_pkg::LT_SKIP, rsld_pkg::LT_PAIRS: begin
                    end
                    rsld_pkg::LT_EMPTY: begin
                        emit              = 1'b1;
                        span.span_kind    = rsld_pkg::SK_EOL;
                        span.last_of_line = 1'b1;
                    end
                    default: begin
                        emit              = 1'b1;
                        span.span_kind    = rsld_pkg::SK_UNKNOWN;
                        span.last_of_line = 1'b1;
                    end
                endcase
            end
            rsld_pkg::PH_DIRECT: begin
                emit              = 1'b1;
                span.span_length  = 8'd1;
                span.use_pixel    = 1'b1;
                span.last_of_line = (bl_dec == '0);
            end
            rsld_pkg::PH_COUNT: begin
                if (b == 8'd0) begin
                    if (r_line_kind != 2'd3) begin
                        emit              = 1'b1;
                        span.span_kind    = rsld_pkg::SK_EOL;
                        span.last_of_line = 1'b1;
                    end
                end else if (!b[7] && (r_line_kind == 2'd2)) begin
                    emit             = 1'b1;
                    span.span_kind   = rsld_pkg::SK_SKIP;
                    span.span_length = b;
                end
            end
            rsld_pkg::PH_LITERAL: begin
                emit             = 1'b1;
                span.span_length = 8'd1;
                span.use_pixel   = 1'b1;
            end
            rsld_pkg::PH_REPEAT: begin
                emit             = 1'b1;
                span.span_length = {1'b0, r_repeat};
                span.use_pixel   = 1'b1;
            end
            rsld_pkg::PH_LEAD: begin
                emit             = 1'b1;
                span.span_kind   = rsld_pkg::SK_SKIP;
                span.span_length = b;
            end
            rsld_pkg::PH_TERM: begin
                emit = 1'b1;
                if (b == rsld_pkg::END_MARK) begin
                    span.span_kind    = rsld_pkg::SK_EOL;
                    span.last_of_line = 1'b1;
                end else begin
                    span.span_kind   = rsld_pkg::SK_SKIP;
                    span.span_length = b;
                end
            end
            default: begin
            end
        endcase
    end

    rsld_ram #(
        .WIDTH (rsld_pkg::PALETTE_W),
        .DEPTH (rsld_pkg::PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_en    (in_accept),
        .i_we    (i_in_data.kind == rsld_pkg::KIND_TABLE),
        .i_addr  ((i_in_data.kind == rsld_pkg::KIND_TABLE) ? i_in_data.table_index : b),
        .i_wdata (b),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_accept) begin
            n_s1_valid = stream_accept && emit;
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_move) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= rsld_pkg::LINE_WIDTH_RST;
            r_phase      <= rsld_pkg::PH_TYPE;
            r_line_kind  <= 2'd0;
            r_bytes_left <= '0;
            r_repeat     <= 7'd0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_write && (paddr[rsld_pkg::PADDR_W-1:2] == rsld_pkg::REG_LINE_WIDTH)) begin
                r_line_width <= pwdata[LW_W-1:0];
            end
            if (stream_accept) begin
                r_phase      <= n_phase;
                r_line_kind  <= n_line_kind;
                r_bytes_left <= n_bytes_left;
                r_repeat     <= n_repeat;
            end
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stream_accept) begin
            r_s1_meta <= span;
        end
        if (s1_move) begin
            r_out.span_kind    <= r_s1_meta.span_kind;
            r_out.pixel        <= r_s1_meta.use_pixel ? ram_rdata : 8'd0;
            r_out.span_length  <= r_s1_meta.span_length;
            r_out.last_of_line <= r_s1_meta.last_of_line;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[rsld_pkg::PADDR_W-1:2] == rsld_pkg::REG_LINE_WIDTH)
                         ? rsld_pkg::PDATA_W'(r_line_width) : '0;

endmodule

@@ rtl/rsld_ram.sv @@
// Generic single-port synchronous RAM with a registered read port.
// Depends on nothing; instantiated by rle_sprite_line_decoder_unit.
module rsld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
